// ===== rtl/core/kpi_pkg.sv =====
// kpi_pkg: shared types and constants for the keyframe position interpolator
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package kpi_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int DIFF_W   = POS_W + 1;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = FRAC_W + 1 + DIFF_W;
    localparam int IDX_W    = 6;
    localparam int SEG_W    = 6;
    localparam int CFG_W    = 7;
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;

    // stream word widths
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 1;

    // item kind carried in the input tuser
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_FETCH_S,
        ST_FETCH_E,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    // key memory read address source
    typedef enum logic [1:0] {
        RD_FIRST,
        RD_SEARCH,
        RD_SEG,
        RD_NXT
    } t_rd_sel;

    // controller to datapath commands
    typedef struct packed {
        logic    wr_key;
        logic    capture;
        logic    cnt_clear;
        logic    cnt_step;
        logic    seg_single;
        logic    seg_hit;
        logic    seg_miss;
        t_rd_sel rd_sel;
        logic    latch_start;
        logic    latch_end;
        logic    div_start;
        logic    mul;
        logic    add;
        logic    out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic single;
        logic hit;
        logic last;
        logic div_busy;
        logic last_axis;
        logic out_busy;
    } t_status;

endpackage

// ===== rtl/core/kpi_frac_div.sv =====
// kpi_frac_div: restoring divider for the 16-bit interpolation factor
// depends on kpi_pkg; one quotient bit per cycle
`timescale 1ns / 1ps

module kpi_frac_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_zero,
    input  logic [kpi_pkg::TIME_W-1:0] i_num,
    input  logic [kpi_pkg::TIME_W-1:0] i_den,
    output logic                       o_busy,
    output logic [kpi_pkg::FRAC_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(kpi_pkg::FRAC_W + 1);

    logic [CNT_W-1:0]            r_cnt;
    logic [kpi_pkg::TIME_W:0]    r_rem;
    logic [kpi_pkg::TIME_W-1:0]  r_den;
    logic [kpi_pkg::FRAC_W-1:0]  r_quo;

    logic [kpi_pkg::TIME_W:0]    rem_shift;
    logic [kpi_pkg::TIME_W:0]    rem_sub;
    logic                        rem_ge;

    // one shift and trial subtract; remainder stays below the divisor
    always_comb begin
        rem_shift = {r_rem[kpi_pkg::TIME_W-1:0], 1'b0};
        rem_ge    = rem_shift >= {1'b0, r_den};
        rem_sub   = rem_shift - {1'b0, r_den};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_zero ? '0 : CNT_W'(kpi_pkg::FRAC_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= rem_ge ? rem_sub : rem_shift;
            r_quo <= {r_quo[kpi_pkg::FRAC_W-2:0], rem_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/kpi_datapath.sv =====
// kpi_datapath: key memories, segment search registers, factor divider,
// shared lerp multiplier and output register; depends on kpi_pkg, kpi_frac_div
`timescale 1ns / 1ps

module kpi_datapath #(
    parameter int MAX_KEYS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kpi_pkg::t_cmd                 i_cmd,
    output kpi_pkg::t_status              o_status,
    input  logic                          i_cfg_valid,
    input  logic [kpi_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [kpi_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kpi_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [kpi_pkg::M_TUSER_W-1:0] o_m_tuser
);

    localparam int KW    = $clog2(MAX_KEYS);
    localparam int NW    = KW + 1;
    localparam int TW    = kpi_pkg::TIME_W;
    localparam int PW    = kpi_pkg::POS_W;
    localparam int IW    = kpi_pkg::IDX_W;
    localparam int M_PAD = kpi_pkg::M_TDATA_W - 3 * PW - kpi_pkg::SEG_W;

    // input word fields
    logic [IW-1:0] s_idx;
    logic [TW-1:0] s_time;
    logic [PW-1:0] s_x;
    logic [PW-1:0] s_y;
    logic [PW-1:0] s_z;

    assign s_idx  = i_s_tdata[IW-1:0];
    assign s_time = i_s_tdata[IW+TW-1:IW];
    assign s_x    = i_s_tdata[IW+TW+PW-1:IW+TW];
    assign s_y    = i_s_tdata[IW+TW+2*PW-1:IW+TW+PW];
    assign s_z    = i_s_tdata[IW+TW+3*PW-1:IW+TW+2*PW];

    // key memories
    logic [TW-1:0] mem_time [0:MAX_KEYS-1];
    logic [PW-1:0] mem_x    [0:MAX_KEYS-1];
    logic [PW-1:0] mem_y    [0:MAX_KEYS-1];
    logic [PW-1:0] mem_z    [0:MAX_KEYS-1];

    logic [TW-1:0] r_rd_time;
    logic [PW-1:0] r_rd_x;
    logic [PW-1:0] r_rd_y;
    logic [PW-1:0] r_rd_z;

    // control and payload registers
    logic [kpi_pkg::CFG_W-1:0]        r_kiu;
    logic [NW-1:0]                    r_n;
    logic [TW-1:0]                    r_t;
    logic [KW-1:0]                    r_cnt;
    logic [KW-1:0]                    r_seg;
    logic                             r_found;
    logic                             r_oor;
    logic [TW-1:0]                    r_t0;
    logic [TW-1:0]                    r_t1;
    logic [PW-1:0]                    r_start [0:kpi_pkg::NUM_AXES-1];
    logic signed [kpi_pkg::DIFF_W-1:0] r_diff [0:kpi_pkg::NUM_AXES-1];
    logic [kpi_pkg::AXIS_W-1:0]       r_axis;
    logic signed [kpi_pkg::PROD_W-1:0] r_prod;
    logic [PW-1:0]                    r_pos [0:kpi_pkg::NUM_AXES-1];
    logic                             r_m_valid;
    logic [PW-1:0]                    r_out_x;
    logic [PW-1:0]                    r_out_y;
    logic [PW-1:0]                    r_out_z;
    logic [kpi_pkg::SEG_W-1:0]        r_out_seg;
    logic                             r_out_oor;

    logic                             wr_en;
    logic [KW-1:0]                    wr_addr;
    logic [KW-1:0]                    rd_addr;
    logic [KW-1:0]                    nxt;
    logic [NW-1:0]                    n_count;
    logic                             div_needed;
    logic                             div_busy;
    logic [kpi_pkg::FRAC_W-1:0]       div_quo;

    // load write, slots beyond the table are dropped
    assign wr_en   = i_cmd.wr_key && (32'(s_idx) < 32'(MAX_KEYS));
    assign wr_addr = KW'(s_idx);
    assign nxt     = r_found ? r_seg + KW'(1) : r_seg;

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            kpi_pkg::RD_FIRST:  rd_addr = KW'(1);
            kpi_pkg::RD_SEARCH: rd_addr = r_cnt + KW'(2);
            kpi_pkg::RD_SEG:    rd_addr = r_seg;
            kpi_pkg::RD_NXT:    rd_addr = nxt;
            default:            rd_addr = r_seg;
        endcase
    end

    // key memories, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_time[wr_addr] <= s_time;
            mem_x[wr_addr]    <= s_x;
            mem_y[wr_addr]    <= s_y;
            mem_z[wr_addr]    <= s_z;
        end
        r_rd_time <= mem_time[rd_addr];
        r_rd_x    <= mem_x[rd_addr];
        r_rd_y    <= mem_y[rd_addr];
        r_rd_z    <= mem_z[rd_addr];
    end

    // effective key count, clamped to 1..MAX_KEYS
    always_comb begin
        if (r_kiu == '0) begin
            n_count = NW'(1);
        end else if (32'(r_kiu) > 32'(MAX_KEYS)) begin
            n_count = NW'(MAX_KEYS);
        end else begin
            n_count = NW'(r_kiu);
        end
    end

    // config register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kiu     <= kpi_pkg::CFG_W'(1);
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_kiu <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // query, search and segment registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_t <= s_time;
            r_n <= n_count;
        end
        if (i_cmd.cnt_clear) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_step) begin
            r_cnt <= r_cnt + KW'(1);
        end
        if (i_cmd.seg_single) begin
            r_seg   <= '0;
            r_found <= 1'b0;
            r_oor   <= 1'b0;
        end else if (i_cmd.seg_hit) begin
            r_seg   <= r_cnt;
            r_found <= 1'b1;
            r_oor   <= 1'b0;
            r_t1    <= r_rd_time;
        end else if (i_cmd.seg_miss) begin
            r_seg   <= KW'(r_n - NW'(1));
            r_found <= 1'b0;
            r_oor   <= 1'b1;
        end
    end

    // start key and per-axis differences
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_start) begin
            r_t0       <= r_rd_time;
            r_start[0] <= r_rd_x;
            r_start[1] <= r_rd_y;
            r_start[2] <= r_rd_z;
        end
        if (i_cmd.latch_end) begin
            r_diff[0] <= kpi_pkg::DIFF_W'($signed(r_rd_x))
                       - kpi_pkg::DIFF_W'($signed(r_start[0]));
            r_diff[1] <= kpi_pkg::DIFF_W'($signed(r_rd_y))
                       - kpi_pkg::DIFF_W'($signed(r_start[1]));
            r_diff[2] <= kpi_pkg::DIFF_W'($signed(r_rd_z))
                       - kpi_pkg::DIFF_W'($signed(r_start[2]));
        end
    end

    // factor divider, skipped when no segment is found, for zero gap or time at or before the start key
    assign div_needed = r_found && (r_t > r_t0) && (r_t1 > r_t0);

    kpi_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_zero  (!div_needed),
        .i_num   (r_t - r_t0),
        .i_den   (r_t1 - r_t0),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // shared multiplier, then floor shift and add, one axis at a time
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_axis <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= kpi_pkg::PROD_W'($signed({1'b0, div_quo}))
                    * kpi_pkg::PROD_W'(r_diff[r_axis]);
        end
        if (i_cmd.add) begin
            r_pos[r_axis] <= r_start[r_axis]
                           + r_prod[kpi_pkg::FRAC_W+PW-1:kpi_pkg::FRAC_W];
            r_axis        <= r_axis + kpi_pkg::AXIS_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x   <= r_pos[0];
            r_out_y   <= r_pos[1];
            r_out_z   <= r_pos[2];
            r_out_seg <= kpi_pkg::SEG_W'(r_seg);
            r_out_oor <= r_oor;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{M_PAD{1'b0}}, r_out_seg, r_out_z, r_out_y, r_out_x};
    assign o_m_tuser  = r_out_oor;

    // status to the controller
    always_comb begin
        o_status.single    = r_n == NW'(1);
        o_status.hit       = r_t < r_rd_time;
        o_status.last      = (NW'(r_cnt) + NW'(2)) >= r_n;
        o_status.div_busy  = div_busy;
        o_status.last_axis = r_axis == kpi_pkg::AXIS_W'(kpi_pkg::NUM_AXES - 1);
        o_status.out_busy  = r_m_valid && !i_m_tready;
    end

endmodule

// ===== rtl/core/kpi_ctrl.sv =====
// kpi_ctrl: sequencer for loads, segment search, division and lerp steps
// depends on kpi_pkg; drives the datapath by command and status structs
`timescale 1ns / 1ps

module kpi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_func,
    input  kpi_pkg::t_status i_status,
    output logic             o_s_tready,
    output kpi_pkg::t_cmd    o_cmd
);

    kpi_pkg::t_state r_state;
    kpi_pkg::t_state n_state;
    logic            accept;

    assign o_s_tready = r_state == kpi_pkg::ST_IDLE;
    assign accept     = i_s_tvalid && o_s_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kpi_pkg::ST_IDLE: begin
                if (accept && i_func == kpi_pkg::FUNC_QUERY) begin
                    n_state = kpi_pkg::ST_START;
                end
            end
            kpi_pkg::ST_START: begin
                n_state = i_status.single ? kpi_pkg::ST_FETCH_S : kpi_pkg::ST_SEARCH;
            end
            kpi_pkg::ST_SEARCH: begin
                if (i_status.hit || i_status.last) begin
                    n_state = kpi_pkg::ST_FETCH_S;
                end
            end
            kpi_pkg::ST_FETCH_S:  n_state = kpi_pkg::ST_FETCH_E;
            kpi_pkg::ST_FETCH_E:  n_state = kpi_pkg::ST_DIV_GO;
            kpi_pkg::ST_DIV_GO:   n_state = kpi_pkg::ST_DIV_WAIT;
            kpi_pkg::ST_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = kpi_pkg::ST_MUL;
                end
            end
            kpi_pkg::ST_MUL:      n_state = kpi_pkg::ST_ADD;
            kpi_pkg::ST_ADD: begin
                n_state = i_status.last_axis ? kpi_pkg::ST_DONE : kpi_pkg::ST_MUL;
            end
            kpi_pkg::ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = kpi_pkg::ST_IDLE;
                end
            end
            default: n_state = kpi_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = kpi_pkg::RD_SEG;
        unique case (r_state)
            kpi_pkg::ST_IDLE: begin
                o_cmd.wr_key  = accept && i_func == kpi_pkg::FUNC_LOAD;
                o_cmd.capture = accept && i_func == kpi_pkg::FUNC_QUERY;
            end
            kpi_pkg::ST_START: begin
                if (i_status.single) begin
                    o_cmd.seg_single = 1'b1;
                end else begin
                    o_cmd.rd_sel    = kpi_pkg::RD_FIRST;
                    o_cmd.cnt_clear = 1'b1;
                end
            end
            kpi_pkg::ST_SEARCH: begin
                o_cmd.rd_sel = kpi_pkg::RD_SEARCH;
                if (i_status.hit) begin
                    o_cmd.seg_hit = 1'b1;
                end else if (i_status.last) begin
                    o_cmd.seg_miss = 1'b1;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            kpi_pkg::ST_FETCH_S: begin
                o_cmd.rd_sel = kpi_pkg::RD_SEG;
            end
            kpi_pkg::ST_FETCH_E: begin
                o_cmd.latch_start = 1'b1;
                o_cmd.rd_sel      = kpi_pkg::RD_NXT;
            end
            kpi_pkg::ST_DIV_GO: begin
                o_cmd.latch_end = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            kpi_pkg::ST_DIV_WAIT: begin
                o_cmd.rd_sel = kpi_pkg::RD_SEG;
            end
            kpi_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            kpi_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
            end
            kpi_pkg::ST_DONE: begin
                o_cmd.out_load = !i_status.out_busy;
            end
            default: begin
                o_cmd.rd_sel = kpi_pkg::RD_SEG;
            end
        endcase
    end

endmodule

// ===== rtl/core/keyframe_position_interpolator.sv =====
// keyframe_position_interpolator: top level, linear keyframe position lerp
// depends on kpi_pkg, kpi_ctrl, kpi_datapath (and kpi_frac_div below it)
//
// input stream: tuser[0] = func (0 load a key, 1 query). a load writes the
// key slot at once, with no result word. a query gives one result word on
// the output stream.
// a query's result word comes after the search has walked k keys
// (1 .. keys_in_use - 1; none with a single key); the next word can be
// taken once the result word is loaded into the output register. the
// search reads the key time memory one key per cycle, then a 16-step
// restoring divider forms the factor and one shared multiplier does x,
// y, z in turn.
// one item is worked on at a time; the input is ready only between items.
// the output register holds a finished word while the receiver stalls and
// the next item is accepted meanwhile; a later query waits for it to drain.
// config channel: one write sets keys_in_use; write it only while idle.
// reset sets keys_in_use to 1 and empties the output; the key memories
// hold no defined value until loaded, and there is no clearing pass.
`timescale 1ns / 1ps

module keyframe_position_interpolator #(
    parameter int MAX_KEYS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata from bit 0: key_index, time_value, load_x, load_y, load_z, zero pad
    input  logic [kpi_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser from bit 0: func
    input  logic [kpi_pkg::S_TUSER_W-1:0] i_s_tuser,
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata from bit 0: pos_x, pos_y, pos_z, segment, zero pad
    output logic [kpi_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tuser from bit 0: out_of_range
    output logic [kpi_pkg::M_TUSER_W-1:0] o_m_tuser,
    // config write: keys_in_use
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kpi_pkg::CFG_W-1:0]     i_cfg_data
);

    kpi_pkg::t_cmd    cmd;
    kpi_pkg::t_status status;

    // config is always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    kpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (i_s_tuser[0]),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath
    kpi_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // a load never raises a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0] == kpi_pkg::FUNC_LOAD)
        |=> !$rose(o_m_tvalid))
        else $error("result raised by a load word");

    // a query holds off the input while it is worked on
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0] == kpi_pkg::FUNC_QUERY)
        |=> !o_s_tready)
        else $error("input ready right after a query word");

    // a result only appears at the end of query work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result raised while idle");

endmodule

// ===== tb/kpi_result_checker.sv =====
// kpi_result_checker: watches the load, query, config and result channels of the
// keyframe position interpolator, predicts every result word and compares it
// depends on kpi_pkg for stream widths and the item kind codes
`timescale 1ns / 1ps

module kpi_result_checker #(
    parameter int MAX_KEYS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [kpi_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [kpi_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [kpi_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [kpi_pkg::M_TUSER_W-1:0] i_m_tuser,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [kpi_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);

    import kpi_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  seg;
        logic        oor;
    } t_position;

    // shadow key table and register
    logic [31:0]     key_time [MAX_KEYS];
    logic [31:0]     key_x    [MAX_KEYS];
    logic [31:0]     key_y    [MAX_KEYS];
    logic [31:0]     key_z    [MAX_KEYS];
    logic [CFG_W-1:0] keys_cfg;

    t_position expected_positions [$];
    int        mismatches;
    int        results_checked;

    // start + floor(frac * (end - start) / 2^16)
    function automatic logic [31:0] blend_axis(logic [31:0] s, logic [31:0] e,
                                               logic [16:0] frac);
        logic signed [63:0] a;
        logic signed [63:0] d;
        logic signed [63:0] p;
        logic signed [63:0] q;
        a = {{32{s[31]}}, s};
        d = {{32{e[31]}}, e} - a;
        p = $signed({47'd0, frac}) * d;
        q = p >>> 16;
        return a[31:0] + q[31:0];
    endfunction

    // segment search, factor and per-axis blend for one query time
    function automatic t_position interpolate_position(logic [31:0] t);
        int unsigned n;
        int unsigned seg;
        int unsigned nxt;
        logic        found;
        logic [63:0] num;
        logic [63:0] gap;
        logic [63:0] ratio;
        logic [16:0] frac;
        t_position   r;
        n = keys_cfg;
        if (n < 1) n = 1;
        if (n > MAX_KEYS) n = MAX_KEYS;
        seg   = 0;
        found = 1'b0;
        r.oor = 1'b0;
        if (n > 1) begin
            for (int unsigned i = 0; i + 1 < n; i++) begin
                if (!found && t < key_time[i+1]) begin
                    seg   = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                seg   = n - 1;
                r.oor = 1'b1;
            end
        end
        nxt  = seg;
        frac = '0;
        if (found) begin
            nxt = seg + 1;
            if (t > key_time[seg] && key_time[nxt] > key_time[seg]) begin
                gap   = 64'(key_time[nxt]) - 64'(key_time[seg]);
                num   = (64'(t) - 64'(key_time[seg])) << 16;
                ratio = num / gap;
                frac  = (ratio > 64'd65535) ? 17'd65535 : ratio[16:0];
            end
        end
        r.x   = blend_axis(key_x[seg], key_x[nxt], frac);
        r.y   = blend_axis(key_y[seg], key_y[nxt], frac);
        r.z   = blend_axis(key_z[seg], key_z[nxt], frac);
        r.seg = seg[5:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_position got;
        t_position want;
        if (!i_rst_n) begin
            keys_cfg = 1;
            for (int i = 0; i < MAX_KEYS; i++) begin
                key_time[i] = '0;
                key_x[i]    = '0;
                key_y[i]    = '0;
                key_z[i]    = '0;
            end
            expected_positions.delete();
            mismatches      = 0;
            results_checked = 0;
        end else begin
            // result side first, so a query taken this edge cannot match it
            if (i_m_tvalid && i_m_tready) begin
                got.x   = i_m_tdata[31:0];
                got.y   = i_m_tdata[63:32];
                got.z   = i_m_tdata[95:64];
                got.seg = i_m_tdata[101:96];
                got.oor = i_m_tuser[0];
                if (expected_positions.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word with nothing expected: x=%h y=%h z=%h seg=%0d oor=%0d",
                                 $time, got.x, got.y, got.z, got.seg, got.oor);
                    mismatches++;
                end else begin
                    want = expected_positions.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch exp x=%h y=%h z=%h seg=%0d oor=%0d, got x=%h y=%h z=%h seg=%0d oor=%0d",
                                     $time, want.x, want.y, want.z, want.seg, want.oor,
                                     got.x, got.y, got.z, got.seg, got.oor);
                        mismatches++;
                    end
                end
            end
            // register write
            if (i_cfg_valid && i_cfg_ready)
                keys_cfg = i_cfg_data;
            // load or query word
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == FUNC_LOAD) begin
                    key_time[i_s_tdata[5:0]] = i_s_tdata[37:6];
                    key_x[i_s_tdata[5:0]]    = i_s_tdata[69:38];
                    key_y[i_s_tdata[5:0]]    = i_s_tdata[101:70];
                    key_z[i_s_tdata[5:0]]    = i_s_tdata[133:102];
                end else begin
                    expected_positions.push_back(interpolate_position(i_s_tdata[37:6]));
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_positions.size();
        o_checked <= results_checked;
    end

endmodule

// ===== tb/keyframe_position_interpolator_tb.sv =====
// keyframe_position_interpolator_tb: drives key loads, queries and register writes
// into the interpolator and gives the verdict from the result checker's count
// depends on kpi_pkg, keyframe_position_interpolator and kpi_result_checker
`timescale 1ns / 1ps

module keyframe_position_interpolator_tb;

    import kpi_pkg::*;

    localparam int          MAX_KEYS      = 64;
    localparam int          PHASES        = 20;
    localparam int          PHASE_ITEMS   = 85;
    localparam int          SETTLE_CYCLES = 128;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = 7'd1;

    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_cfg_ready;

    int chk_errors;
    int chk_pending;
    int chk_checked;

    // stimulus bookkeeping
    logic        calm = 1'b0;
    logic [31:0] shadow_time [MAX_KEYS];
    int          keys_eff    = 1;
    int          n_words     = 0;
    int          n_queries   = 0;
    int          n_settings  = 0;
    int unsigned cycle_count = 0;

    keyframe_position_interpolator #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    kpi_result_checker #(
        .MAX_KEYS (MAX_KEYS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls about 15 percent of the time, never while calm
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // position with a bias toward the extremes and small values
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // offer one word and hold it until taken; valid stays high for a follow-on word
    task automatic drive_word(t_func f, logic [5:0] idx, logic [31:0] tv,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= f;
        s_tdata    <= {2'b00, z, y, x, tv, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (f == FUNC_LOAD)
            shadow_time[idx] = tv;
        else
            n_queries++;
        n_words++;
    endtask

    // stop offering, wait for all results, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keys_in_use(logic [CFG_W-1:0] v);
        settle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        keys_eff = (v == 0) ? 1 : ((v > MAX_KEYS) ? MAX_KEYS : int'(v));
        n_settings++;
    endtask

    initial begin
        logic [31:0] tv;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tcur;
        logic [5:0]  idx;
        int          r;
        int          k;
        logic [CFG_W-1:0] cfg_v;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single key with extreme positions
        drive_word(FUNC_LOAD, 6'd0, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        drive_word(FUNC_QUERY, 6'd63, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        drive_word(FUNC_QUERY, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        // zero register acts as one key
        write_keys_in_use(7'd0);
        drive_word(FUNC_QUERY, 6'd21, 32'h0000_0100, $urandom, $urandom, $urandom);

        // four keys: zero gap between keys 0 and 1, last key at the top of time
        write_keys_in_use(7'd4);
        drive_word(FUNC_LOAD, 6'd1, 32'h0000_0100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        drive_word(FUNC_LOAD, 6'd2, 32'h0000_1000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000);
        drive_word(FUNC_LOAD, 6'd3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drive_word(FUNC_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'h0000_00FF, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'h0000_0100, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'h0000_0800, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'h0000_1001, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        // unsorted table: key 2 earlier than key 1
        drive_word(FUNC_LOAD, 6'd2, 32'h0000_0010, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        drive_word(FUNC_QUERY, 6'd0, 32'h0000_0080, 32'h0, 32'h0, 32'h0);
        drive_word(FUNC_QUERY, 6'd0, 32'h0000_0200, 32'h0, 32'h0, 32'h0);

        // random phases, each under one register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 9 || ph == 10);

            // fresh sorted table now and then, with some zero and tiny gaps
            if (ph % 5 == 0) begin
                tcur = $urandom_range(32'h0000_FFFF);
                for (int key = 0; key < MAX_KEYS; key++) begin
                    drive_word(FUNC_LOAD, 6'(key), tcur, rand_pos(), rand_pos(), rand_pos());
                    r = $urandom_range(99);
                    if (r < 10)
                        tcur = tcur;
                    else if (r < 30)
                        tcur = tcur + $urandom_range(16, 1);
                    else
                        tcur = tcur + $urandom_range(32'h03FF_FFFF, 1);
                end
            end

            case (ph)
                0:       cfg_v = 7'd64;
                1:       cfg_v = 7'd127;
                2:       cfg_v = 7'd1;
                3:       cfg_v = 7'd0;
                4:       cfg_v = 7'd65;
                5:       cfg_v = 7'd2;
                default: begin
                    r = $urandom_range(99);
                    if (r < 70)
                        cfg_v = 7'($urandom_range(64, 2));
                    else if (r < 85)
                        cfg_v = 7'($urandom_range(127, 65));
                    else
                        cfg_v = 7'($urandom_range(1));
                end
            endcase
            write_keys_in_use(cfg_v);

            for (int it = 0; it < PHASE_ITEMS; it++) begin
                if ($urandom_range(99) < 20) begin
                    // key rewrite, mostly keeping the order of its neighbors
                    idx = 6'($urandom_range(63));
                    lo  = (idx == 0) ? 32'h0 : shadow_time[idx-1];
                    hi  = (idx == 63) ? 32'hFFFF_FFFF : shadow_time[idx+1];
                    if ($urandom_range(99) < 85 && lo <= hi)
                        tv = $urandom_range(hi, lo);
                    else
                        tv = $urandom;
                    drive_word(FUNC_LOAD, idx, tv, rand_pos(), rand_pos(), rand_pos());
                end else begin
                    // query time: inside a segment, on a key, past the end, before the start or anywhere
                    r = $urandom_range(99);
                    if (r < 50 && keys_eff > 1) begin
                        k  = $urandom_range(keys_eff - 2);
                        lo = shadow_time[k];
                        hi = shadow_time[k+1];
                        tv = (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
                    end else if (r < 65) begin
                        tv = shadow_time[$urandom_range(keys_eff - 1)];
                    end else if (r < 75) begin
                        lo = shadow_time[keys_eff-1];
                        if (lo == 32'hFFFF_FFFF || $urandom_range(1) == 0)
                            tv = 32'hFFFF_FFFF;
                        else
                            tv = $urandom_range(32'hFFFF_FFFF, lo + 1);
                    end else if (r < 85) begin
                        tv = (shadow_time[0] == 0) ? 32'h0 : $urandom_range(shadow_time[0] - 1);
                    end else begin
                        tv = $urandom;
                    end
                    drive_word(FUNC_QUERY, 6'($urandom_range(63)), tv,
                               $urandom, $urandom, $urandom);
                end
            end
        end

        calm = 1'b0;
        settle();
        $display("summary: %0d words sent, %0d of them queries, %0d results checked, %0d register settings",
                 n_words, n_queries, chk_checked, n_settings);
        $display("summary: single key, clamped register values, zero gaps, unsorted keys, times past both ends, 64-key searches");
        if (chk_errors == 0 && chk_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
